### hw/rtl/pphp_pkg.sv
`default_nettype none
package pphp_pkg;

  localparam logic [3:0] PP_VERSION = 4'h2;
  localparam logic [3:0] CMD_LOCAL  = 4'h0;
  localparam logic [3:0] CMD_PROXY  = 4'h1;
  localparam logic [3:0] FAM_UNSPEC = 4'h0;
  localparam logic [3:0] FAM_INET   = 4'h1;
  localparam logic [3:0] FAM_INET6  = 4'h2;
  localparam logic [3:0] FAM_UNIX   = 4'h3;

  localparam logic [15:0] INET_BLOCK  = 16'(4 + 4 + 2 + 2);
  localparam logic [15:0] INET6_BLOCK = 16'(16 + 16 + 2 + 2);

  // byte positions within the header
  localparam logic [4:0] POS_VER_CMD = 5'd12;
  localparam logic [4:0] POS_FAMILY  = 5'd13;
  localparam logic [4:0] POS_LEN_HI  = 5'd14;
  localparam logic [4:0] POS_LEN_LO  = 5'd15;
  localparam logic [4:0] POS_INET_END  = 5'd19;
  localparam logic [4:0] POS_INET6_END = 5'd31;

  localparam logic [2:0] ST_PROXY_OK   = 3'd0;
  localparam logic [2:0] ST_LOCAL_OK   = 3'd1;
  localparam logic [2:0] ST_BAD_SIG    = 3'd2;
  localparam logic [2:0] ST_BAD_VER    = 3'd3;
  localparam logic [2:0] ST_BAD_CMD    = 3'd4;
  localparam logic [2:0] ST_BAD_FAM    = 3'd5;
  localparam logic [2:0] ST_NO_ADDR    = 3'd6;
  localparam logic [2:0] ST_LEN_SHORT  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        command_code;
    logic [1:0]  family_code;
    logic [15:0] declared_length;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } out_word_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0:    v = 8'h0D;
      4'd1:    v = 8'h0A;
      4'd2:    v = 8'h0D;
      4'd3:    v = 8'h0A;
      4'd4:    v = 8'h00;
      4'd5:    v = 8'h0D;
      4'd6:    v = 8'h0A;
      4'd7:    v = 8'h51;
      4'd8:    v = 8'h55;
      4'd9:    v = 8'h49;
      4'd10:   v = 8'h54;
      4'd11:   v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pphp_parse.sv
`default_nettype none
module pphp_parse
  import pphp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      word_valid,
  input  wire in_word_t  word,
  input  wire logic      advance,
  output logic           res_valid,
  output out_word_t      res
);

  logic [4:0]   pos_r, pos_nxt;
  logic         sig_ok_r, sig_ok_nxt;
  logic [3:0]   ver_r, ver_nxt;
  logic [3:0]   cmd_r, cmd_nxt;
  logic [3:0]   fam_r, fam_nxt;
  logic [15:0]  len_r, len_nxt;
  logic [127:0] addr_r, addr_nxt;
  logic         done_r, done_nxt;

  always_comb begin
    logic       emit;
    logic       with_addr;
    logic [2:0] st;
    logic [7:0] b;
    b          = word.data_byte;
    emit       = 1'b0;
    with_addr  = 1'b0;
    st         = ST_PROXY_OK;
    pos_nxt    = pos_r;
    sig_ok_nxt = sig_ok_r;
    ver_nxt    = ver_r;
    cmd_nxt    = cmd_r;
    fam_nxt    = fam_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    done_nxt   = done_r;
    // restart on a first byte
    if (word.first_byte) begin
      pos_nxt    = '0;
      sig_ok_nxt = 1'b1;
      ver_nxt    = '0;
      cmd_nxt    = '0;
      fam_nxt    = '0;
      len_nxt    = '0;
      addr_nxt   = '0;
      done_nxt   = 1'b0;
    end
    if (!done_nxt) begin
      if (pos_nxt < POS_VER_CMD) begin
        if (b != sig_byte(pos_nxt[3:0])) sig_ok_nxt = 1'b0;
      end else if (pos_nxt == POS_VER_CMD) begin
        ver_nxt = b[7:4];
        cmd_nxt = b[3:0];
      end else if (pos_nxt == POS_FAMILY) begin
        fam_nxt = b[7:4];
      end else if (pos_nxt == POS_LEN_HI) begin
        len_nxt = {b, 8'h00};
      end else if (pos_nxt == POS_LEN_LO) begin
        len_nxt = {len_nxt[15:8], b};
        emit = 1'b1;
        priority if (!sig_ok_nxt)                           st = ST_BAD_SIG;
        else if (ver_nxt != PP_VERSION)                     st = ST_BAD_VER;
        else if (cmd_nxt > CMD_PROXY)                       st = ST_BAD_CMD;
        else if (fam_nxt > FAM_UNIX)                        st = ST_BAD_FAM;
        else if (cmd_nxt == CMD_LOCAL)                      st = ST_LOCAL_OK;
        else if (fam_nxt != FAM_INET && fam_nxt != FAM_INET6) st = ST_NO_ADDR;
        else if (len_nxt < ((fam_nxt == FAM_INET) ? INET_BLOCK : INET6_BLOCK))
          st = ST_LEN_SHORT;
        else
          emit = 1'b0;
      end else begin
        addr_nxt = {addr_nxt[119:0], b};
        if ((fam_nxt == FAM_INET && pos_nxt == POS_INET_END) ||
            (fam_nxt == FAM_INET6 && pos_nxt == POS_INET6_END)) begin
          emit      = 1'b1;
          with_addr = 1'b1;
          st        = ST_PROXY_OK;
        end
      end
      if (emit) done_nxt = 1'b1;
      else      pos_nxt  = pos_nxt + 5'd1;
    end
    res_valid            = word_valid && emit;
    res.status           = st;
    res.command_code     = (cmd_nxt <= CMD_PROXY) ? cmd_nxt[0] : 1'b0;
    res.family_code      = (fam_nxt <= FAM_UNIX) ? fam_nxt[1:0] : 2'd0;
    res.declared_length  = len_nxt;
    res.address_high     = with_addr ? addr_nxt[127:64] : 64'd0;
    res.address_low      = with_addr ? addr_nxt[63:0] : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sig_ok_r <= 1'b1;
      ver_r    <= '0;
      cmd_r    <= '0;
      fam_r    <= '0;
      len_r    <= '0;
      addr_r   <= '0;
      done_r   <= 1'b1;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      sig_ok_r <= sig_ok_nxt;
      ver_r    <= ver_nxt;
      cmd_r    <= cmd_nxt;
      fam_r    <= fam_nxt;
      len_r    <= len_nxt;
      addr_r   <= addr_nxt;
      done_r   <= done_nxt;
    end
  end

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_PROXY_OK |->
      res.address_high == 64'd0 && res.address_low == 64'd0)
    else $error("address set on a result without an address");

  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid |=> done_r)
    else $error("parser still active after its result");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (pos_r <= POS_INET_END || fam_r == FAM_INET6))
    else $error("byte position past the IPv4 address end");

endmodule
`default_nettype wire

### hw/rtl/pphp_out.sv
`default_nettype none
module pphp_out
  import pphp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_word_t res,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_word_t      out_data,
  output logic           busy
);

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  always_comb begin
    if (load)            valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
    else                 valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= res;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  // a new word may only enter once the held one is taken
  assign busy      = valid_r && out_stall;

endmodule
`default_nettype wire

### hw/rtl/proxy_v2_header_parser_core.sv
`default_nettype none
// Channel   Ports                          Word
// input     in_valid  in_stall  in_data    in_word_t  (data_byte, first_byte)
// result    out_valid out_stall out_data   out_word_t (status, fields, address)
//
// One byte is accepted every cycle while in_stall is low; a result passes the
// byte register and then the output register before it shows on out_valid, so it
// is registered twice after the byte that completes a header.
// The byte register feeds the parser, whose state updates when the byte advances.
// Reset is synchronous and active low; the parser starts idle until a first byte.
// A stalled result holds the parser only when the next byte also yields a result;
// other bytes keep flowing past the held result.
module proxy_v2_header_parser_core
  import pphp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      res_valid;
  out_word_t res;
  logic      out_busy;
  logic      go;
  logic      advance;

  assign go       = !(res_valid && out_busy);
  assign advance  = s1_valid_r && go;
  assign in_stall = s1_valid_r && !go;

  always_comb begin
    if (in_valid && !in_stall) s1_valid_nxt = 1'b1;
    else if (advance)          s1_valid_nxt = 1'b0;
    else                       s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_word_r <= in_data;
  end

  pphp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (s1_valid_r),
    .word       (s1_word_r),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  pphp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (out_busy)
  );

endmodule
`default_nettype wire
